FILE: design/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

    localparam logic [15:0] TIMER_IDLE = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_POSITION = 2'd1,
        REQ_SPEED    = 2'd2,
        REQ_SETUP    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLEAR,
        ST_DELIVER
    } ctrl_state_t;

    // One servo's entry as it travels around the ring.
    typedef struct packed {
        logic [7:0]  user_pos;
        logic [7:0]  sent_pos;
        logic [7:0]  speed;
        logic        pending;
        logic [15:0] timer;
        logic [15:0] duration;
        logic        rel_en;
        logic [7:0]  lo;
        logic        lo_on;
        logic [7:0]  hi;
        logic        hi_on;
    } servo_rec_t;

    // Request fields that the head cell needs, latched at the input transfer.
    typedef struct packed {
        req_kind_t   kind;
        logic [7:0]  position_cmd;
        logic [7:0]  speed_cmd;
        logic [7:0]  min_limit;
        logic        min_limit_on;
        logic [7:0]  max_limit;
        logic        max_limit_on;
        logic [15:0] release_ticks;
        logic        release_on;
    } req_item_t;

    typedef struct packed {
        logic tick_step;
        logic cmd_hit;
        logic clear_hit;
    } head_ctl_t;

endpackage

FILE: design/srs_req_if.sv
`timescale 1ns / 1ps

interface srs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [4:0]  servo_number;
    logic [7:0]  position_cmd;
    logic [7:0]  speed_cmd;
    logic [7:0]  min_limit;
    logic        min_limit_on;
    logic [7:0]  max_limit;
    logic        max_limit_on;
    logic [15:0] release_ticks;
    logic        release_on;

    modport source (
        output valid, req_type, servo_number, position_cmd, speed_cmd, min_limit,
               min_limit_on, max_limit, max_limit_on, release_ticks, release_on,
        input  ready
    );

    modport sink (
        input  valid, req_type, servo_number, position_cmd, speed_cmd, min_limit,
               min_limit_on, max_limit, max_limit_on, release_ticks, release_on,
        output ready
    );
endinterface

FILE: design/srs_rsp_if.sv
`timescale 1ns / 1ps

interface srs_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] register_number;
    logic [7:0] position_value;

    modport source (
        output valid, register_number, position_value,
        input  ready
    );

    modport sink (
        input  valid, register_number, position_value,
        output ready
    );
endinterface

FILE: design/srs_cell.sv
`timescale 1ns / 1ps

module srs_cell #(
    parameter int DEFAULT_RELEASE_TICKS = 100
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  srs_pkg::servo_rec_t d,
    output srs_pkg::servo_rec_t q
);
    import srs_pkg::*;

    localparam servo_rec_t ResetRec = '{
        user_pos: 8'd0,
        sent_pos: 8'd0,
        speed:    8'd0,
        pending:  1'b1,
        timer:    TIMER_IDLE,
        duration: 16'(DEFAULT_RELEASE_TICKS),
        rel_en:   1'b1,
        lo:       8'd0,
        lo_on:    1'b0,
        hi:       8'd0,
        hi_on:    1'b0
    };

    servo_rec_t rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= ResetRec;
        end
        else if (shift_en)
        begin
            rec_reg <= d;
        end
    end

    assign q = rec_reg;

endmodule

FILE: design/srs_head.sv
`timescale 1ns / 1ps

module srs_head (
    input  srs_pkg::servo_rec_t cur,
    input  srs_pkg::req_item_t  item,
    input  srs_pkg::head_ctl_t  ctl,
    output srs_pkg::servo_rec_t nxt
);
    import srs_pkg::*;

    logic [7:0]  clamped;
    logic [15:0] bumped;

    always_comb
    begin
        clamped = item.position_cmd;
        if (cur.lo_on && item.position_cmd < cur.lo)
        begin
            clamped = cur.lo;
        end
        // The upper clamp wins when the two clamps conflict.
        if (cur.hi_on && item.position_cmd > cur.hi)
        begin
            clamped = cur.hi;
        end

        bumped = cur.timer + 16'd1;
        nxt    = cur;

        if (ctl.tick_step && cur.timer != TIMER_IDLE)
        begin
            nxt.timer = bumped;
            if (cur.rel_en && bumped > cur.duration)
            begin
                nxt.timer    = TIMER_IDLE;
                nxt.sent_pos = 8'd0;
                nxt.pending  = 1'b1;
            end
        end

        if (ctl.clear_hit)
        begin
            nxt.pending = 1'b0;
        end

        if (ctl.cmd_hit)
        begin
            case (item.kind)
                REQ_POSITION:
                begin
                    if (cur.user_pos != clamped)
                    begin
                        nxt.user_pos = clamped;
                        nxt.sent_pos = clamped;
                        nxt.pending  = 1'b1;
                        if (cur.rel_en)
                        begin
                            nxt.timer = 16'd0;
                        end
                    end
                end
                REQ_SPEED:
                begin
                    if (cur.speed != item.speed_cmd)
                    begin
                        nxt.speed   = item.speed_cmd;
                        nxt.pending = 1'b1;
                    end
                end
                REQ_SETUP:
                begin
                    nxt.lo       = item.min_limit;
                    nxt.lo_on    = item.min_limit_on;
                    nxt.hi       = item.max_limit;
                    nxt.hi_on    = item.max_limit_on;
                    nxt.duration = item.release_ticks;
                    nxt.rel_en   = item.release_on;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: design/servo_refresh_scheduler_core.sv
`timescale 1ns / 1ps
// Sequence: a command, a setup or a tick with nothing pending takes one ring turn in ST_SCAN;
// a tick that finds a pending servo takes a ring turn for timers and the search, a turn in
// ST_CLEAR to clear the flag and ST_DELIVER to load the write, longer while rsp is stalled.
// Throughput: one item at a time; the servo table circulates through a ring of
// cells past a single update head, one entry per cycle while scanning or clearing.
// Reset: asynchronous, active low; every entry returns to its default, all pending.
module servo_refresh_scheduler_core #(
    parameter int NUM_SERVOS            = 20,
    parameter int DEFAULT_RELEASE_TICKS = 100
) (
    input  logic     clk,
    input  logic     rst_n,
    srs_req_if.sink  req,
    srs_rsp_if.source rsp
);
    import srs_pkg::*;

    localparam int IdxW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SERVOS - 1);

    ctrl_state_t state_reg, state_next;
    logic [IdxW-1:0] k_reg, k_next;
    logic [IdxW-1:0] last_reg, last_next;
    logic [IdxW-1:0] hi_idx_reg, hi_idx_next;
    logic [IdxW-1:0] lo_idx_reg, lo_idx_next;
    logic            found_hi_reg, found_hi_next;
    logic            found_lo_reg, found_lo_next;
    req_item_t       item_reg;
    logic [4:0]      sidx_reg;
    logic            addr_ok_reg;
    logic [7:0]      pos_hold_reg;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [4:0]      rsp_num_reg;
    logic [7:0]      rsp_pos_reg;

    servo_rec_t ring_q [NUM_SERVOS];
    servo_rec_t head_nxt;
    head_ctl_t  ctl;
    logic       shift_en;
    logic       in_xfer;
    logic       is_tick;
    logic       out_free;
    logic       load_rsp;

    assign is_tick  = (item_reg.kind == REQ_TICK);
    assign in_xfer  = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign shift_en = (state_reg == ST_SCAN) || (state_reg == ST_CLEAR);

    assign ctl.tick_step = (state_reg == ST_SCAN) && is_tick;
    assign ctl.cmd_hit   = (state_reg == ST_SCAN) && !is_tick && addr_ok_reg
                           && (5'(k_reg) == sidx_reg);
    assign ctl.clear_hit = (state_reg == ST_CLEAR) && (k_reg == last_reg);

    // The entry at cell 0 passes through the head and re-enters at the far end.
    for (genvar i = 0; i < NUM_SERVOS; i++)
    begin : g_ring
        servo_rec_t cell_d;
        if (i == NUM_SERVOS - 1)
        begin : g_tail
            assign cell_d = head_nxt;
        end
        else
        begin : g_mid
            assign cell_d = ring_q[i+1];
        end
        srs_cell #(
            .DEFAULT_RELEASE_TICKS(DEFAULT_RELEASE_TICKS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .d        (cell_d),
            .q        (ring_q[i])
        );
    end

    srs_head u_head (
        .cur  (ring_q[0]),
        .item (item_reg),
        .ctl  (ctl),
        .nxt  (head_nxt)
    );

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        hi_idx_next    = hi_idx_reg;
        lo_idx_next    = lo_idx_reg;
        found_hi_next  = found_hi_reg;
        found_lo_next  = found_lo_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        load_rsp       = 1'b0;
        req.ready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    k_next        = '0;
                    found_hi_next = 1'b0;
                    found_lo_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Round-robin search: first pending entry above the last one
                // served, else the first pending entry overall.
                if (ctl.tick_step && head_nxt.pending)
                begin
                    if (!found_lo_reg)
                    begin
                        found_lo_next = 1'b1;
                        lo_idx_next   = k_reg;
                    end
                    if (!found_hi_reg && k_reg > last_reg)
                    begin
                        found_hi_next = 1'b1;
                        hi_idx_next   = k_reg;
                    end
                end
                k_next = k_reg + IdxW'(1);
                if (k_reg == LastIdx)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                    if (is_tick && (found_hi_next || found_lo_next))
                    begin
                        last_next  = found_hi_next ? hi_idx_next : lo_idx_next;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                k_next = k_reg + IdxW'(1);
                if (k_reg == LastIdx)
                begin
                    k_next     = '0;
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    load_rsp       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            last_reg      <= '0;
            found_hi_reg  <= 1'b0;
            found_lo_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            last_reg      <= last_next;
            found_hi_reg  <= found_hi_next;
            found_lo_reg  <= found_lo_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_idx_reg <= hi_idx_next;
        lo_idx_reg <= lo_idx_next;
        if (in_xfer)
        begin
            item_reg.kind          <= req_kind_t'(req.req_type);
            item_reg.position_cmd  <= req.position_cmd;
            item_reg.speed_cmd     <= req.speed_cmd;
            item_reg.min_limit     <= req.min_limit;
            item_reg.min_limit_on  <= req.min_limit_on;
            item_reg.max_limit     <= req.max_limit;
            item_reg.max_limit_on  <= req.max_limit_on;
            item_reg.release_ticks <= req.release_ticks;
            item_reg.release_on    <= req.release_on;
            sidx_reg               <= req.servo_number - 5'd1;
            addr_ok_reg            <= (req.servo_number != 5'd0)
                                      && (req.servo_number <= 5'(NUM_SERVOS));
        end
        if (ctl.clear_hit)
        begin
            pos_hold_reg <= head_nxt.sent_pos;
        end
        if (load_rsp)
        begin
            rsp_num_reg <= 5'(last_reg) + 5'd1;
            rsp_pos_reg <= pos_hold_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.register_number = rsp_num_reg;
    assign rsp.position_value  = rsp_pos_reg;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import srs_pkg::*;

    localparam int SERVOS        = 20;
    localparam int DEFAULT_TICKS = 100;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int LONG_HOLD     = 3000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        req_kind_t   kind;
        logic [4:0]  num;
        logic [7:0]  pos;
        logic [7:0]  spd;
        logic [7:0]  lo;
        logic        lo_on;
        logic [7:0]  hi;
        logic        hi_on;
        logic [15:0] ticks;
        logic        rel_on;
    } servo_req_t;

    typedef struct packed {
        logic [4:0] reg_num;
        logic [7:0] pos;
    } servo_write_t;

    typedef struct packed {
        servo_req_t   req;
        logic         typed;
        logic         has_write;
        servo_write_t write;
    } dir_row_t;

    logic clk;
    logic rst_n;

    srs_req_if req_ch();
    srs_rsp_if rsp_ch();

    servo_refresh_scheduler_core #(
        .NUM_SERVOS            (SERVOS),
        .DEFAULT_RELEASE_TICKS (DEFAULT_TICKS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow copy of the servo table.
    logic [7:0]  tgt_pos [SERVOS];
    logic [7:0]  out_pos [SERVOS];
    logic [7:0]  spd_val [SERVOS];
    bit          upd     [SERVOS];
    logic [15:0] rel_cnt [SERVOS];
    logic [15:0] rel_len [SERVOS];
    bit          rel_en  [SERVOS];
    logic [7:0]  lo_lim  [SERVOS];
    bit          lo_on   [SERVOS];
    logic [7:0]  hi_lim  [SERVOS];
    bit          hi_on   [SERVOS];
    int          rr_last;

    servo_write_t writes_due[$];

    int  errors;
    int  sent_count;
    int  tick_count;
    int  idle_ticks;
    int  writes_seen;
    int  cycles;
    bit  long_hold_req;
    bit  long_hold_done;
    bit  no_idle_send;

    localparam int DIR_ROWS = 25;
    dir_row_t dir_table [DIR_ROWS] = '{
        // After reset every servo is pending and the search starts after servo 1.
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b1, '{5'd2, 8'd0}},
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b1, '{5'd3, 8'd0}},
        // Servo numbers outside the table are dropped.
        '{'{REQ_POSITION, 5'd0, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_POSITION, 5'd21, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_SETUP, 5'd31, 8'd0, 8'd0, 8'd255, 1'b1, 8'd255, 1'b1, 16'hFFFF, 1'b1},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        // Both clamps on, release right after the first tick.
        '{'{REQ_SETUP, 5'd1, 8'd0, 8'd0, 8'd10, 1'b1, 8'd200, 1'b1, 16'd0, 1'b1},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_POSITION, 5'd1, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd31, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_POSITION, 5'd1, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        // Conflicting clamps with release off.
        '{'{REQ_SETUP, 5'd2, 8'd0, 8'd0, 8'd200, 1'b1, 8'd50, 1'b1, 16'd65534, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_POSITION, 5'd2, 8'd100, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        // A duration of all ones can never be exceeded.
        '{'{REQ_SETUP, 5'd3, 8'd0, 8'd0, 8'd255, 1'b1, 8'd0, 1'b0, 16'hFFFF, 1'b1},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_POSITION, 5'd3, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_SPEED, 5'd3, 8'd0, 8'd255, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_SPEED, 5'd20, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_POSITION, 5'd20, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_SETUP, 5'd20, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1, 16'd1, 1'b1},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_POSITION, 5'd20, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b1, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd17, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}},
        '{'{REQ_TICK, 5'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 16'd0, 1'b0},
          1'b0, 1'b0, '{5'd0, 8'd0}}
    };

    // Applies one request to the shadow table; returns 1 when a tick yields a write.
    function automatic bit advance_servo_table(input servo_req_t r, output servo_write_t w);
        int         idx;
        int         s;
        bit         found;
        logic [7:0] p;

        w = '0;
        if (r.kind == REQ_TICK)
        begin
            for (int i = 0; i < SERVOS; i++)
            begin
                if (rel_cnt[i] != TIMER_IDLE)
                begin
                    rel_cnt[i] = rel_cnt[i] + 16'd1;
                    if (rel_en[i] && rel_cnt[i] > rel_len[i])
                    begin
                        rel_cnt[i] = TIMER_IDLE;
                        out_pos[i] = 8'd0;
                        upd[i]     = 1'b1;
                    end
                end
            end
            s     = rr_last;
            found = 1'b0;
            for (int i = 0; i < SERVOS && !found; i++)
            begin
                s = (s + 1 >= SERVOS) ? 0 : s + 1;
                if (upd[s])
                    found = 1'b1;
            end
            rr_last = s;
            if (!found)
                return 1'b0;
            upd[s]    = 1'b0;
            w.reg_num = 5'(s + 1);
            w.pos     = out_pos[s];
            return 1'b1;
        end

        if (r.num == 5'd0 || r.num > SERVOS)
            return 1'b0;
        idx = r.num - 1;

        case (r.kind)
            REQ_POSITION:
            begin
                // Both clamp tests look at the requested value, not the raised one.
                p = r.pos;
                if (lo_on[idx] && r.pos < lo_lim[idx])
                    p = lo_lim[idx];
                if (hi_on[idx] && r.pos > hi_lim[idx])
                    p = hi_lim[idx];
                if (tgt_pos[idx] != p)
                begin
                    tgt_pos[idx] = p;
                    out_pos[idx] = p;
                    upd[idx]     = 1'b1;
                    if (rel_en[idx])
                        rel_cnt[idx] = 16'd0;
                end
            end
            REQ_SPEED:
            begin
                if (spd_val[idx] != r.spd)
                begin
                    spd_val[idx] = r.spd;
                    upd[idx]     = 1'b1;
                end
            end
            default:
            begin
                lo_lim[idx]  = r.lo;
                lo_on[idx]   = r.lo_on;
                hi_lim[idx]  = r.hi;
                hi_on[idx]   = r.hi_on;
                rel_len[idx] = r.ticks;
                rel_en[idx]  = r.rel_on;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic servo_req_t draw_request(input bit force_tick);
        servo_req_t  r;
        logic [63:0] raw;
        int          pick;

        raw  = {$urandom, $urandom};
        r    = raw[$bits(servo_req_t)-1:0];
        pick = $urandom_range(0, 99);
        if (force_tick || pick < 45)
            r.kind = REQ_TICK;
        else if (pick < 75)
            r.kind = REQ_POSITION;
        else if (pick < 85)
            r.kind = REQ_SPEED;
        else
            r.kind = REQ_SETUP;

        if ($urandom_range(0, 9) == 0)
        begin
            // Servo 0 or one of 21..31.
            r.num = 5'($urandom_range(0, 11));
            if (r.num != 5'd0)
                r.num = r.num + 5'd20;
        end
        else
            r.num = 5'($urandom_range(1, SERVOS));

        if (r.num != 5'd0 && r.num <= SERVOS && $urandom_range(0, 4) == 0)
        begin
            r.pos = tgt_pos[r.num - 1];
            r.spd = spd_val[r.num - 1];
        end

        // Mostly short durations so that releases actually fire.
        pick = $urandom_range(0, 9);
        if (pick < 7)
            r.ticks = 16'($urandom_range(0, 30));
        else if (pick == 9)
        begin
            case ($urandom_range(0, 2))
                0:       r.ticks = 16'd0;
                1:       r.ticks = 16'd65534;
                default: r.ticks = 16'hFFFF;
            endcase
        end
        return r;
    endfunction

    task automatic offer_request(input servo_req_t r, input bit typed,
                                 input bit typed_has, input servo_write_t typed_w);
        int           gap;
        bit           has_w;
        servo_write_t w;

        gap = no_idle_send ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.kind;
        req_ch.servo_number  <= r.num;
        req_ch.position_cmd  <= r.pos;
        req_ch.speed_cmd     <= r.spd;
        req_ch.min_limit     <= r.lo;
        req_ch.min_limit_on  <= r.lo_on;
        req_ch.max_limit     <= r.hi;
        req_ch.max_limit_on  <= r.hi_on;
        req_ch.release_ticks <= r.ticks;
        req_ch.release_on    <= r.rel_on;
        do
            @(posedge clk);
        while (!req_ch.ready);

        has_w = advance_servo_table(r, w);
        if (typed)
        begin
            has_w = typed_has;
            w     = typed_w;
        end
        if (has_w)
            writes_due.push_back(w);
        sent_count++;
        if (r.kind == REQ_TICK)
        begin
            tick_count++;
            if (!has_w)
                idle_ticks++;
        end
    endtask

    initial
    begin : result_sink
        int           gap;
        servo_write_t exp_w;

        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = ((writes_seen / 40) % 4 == 3) ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);

            writes_seen++;
            if (writes_due.size() == 0)
            begin
                $display("%0t: unexpected write, register_number %0d position_value %0d",
                         $time, rsp_ch.register_number, rsp_ch.position_value);
                errors++;
            end
            else
            begin
                exp_w = writes_due.pop_front();
                if (rsp_ch.register_number !== exp_w.reg_num)
                begin
                    $display("%0t: register_number expected %0d, got %0d",
                             $time, exp_w.reg_num, rsp_ch.register_number);
                    errors++;
                end
                if (rsp_ch.position_value !== exp_w.pos)
                begin
                    $display("%0t: position_value expected %0d, got %0d",
                             $time, exp_w.pos, rsp_ch.position_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles, %0d writes outstanding",
                 $time, cycles, writes_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        servo_req_t r;
        int         burst_left;

        errors         = 0;
        sent_count     = 0;
        tick_count     = 0;
        idle_ticks     = 0;
        writes_seen    = 0;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        no_idle_send   = 1'b0;
        burst_left     = 0;

        for (int i = 0; i < SERVOS; i++)
        begin
            tgt_pos[i] = 8'd0;
            out_pos[i] = 8'd0;
            spd_val[i] = 8'd0;
            upd[i]     = 1'b1;
            rel_cnt[i] = TIMER_IDLE;
            rel_len[i] = 16'(DEFAULT_TICKS);
            rel_en[i]  = 1'b1;
            lo_lim[i]  = 8'd0;
            lo_on[i]   = 1'b0;
            hi_lim[i]  = 8'd0;
            hi_on[i]   = 1'b0;
        end
        rr_last = 0;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_TICK;
        req_ch.servo_number  = 5'd0;
        req_ch.position_cmd  = 8'd0;
        req_ch.speed_cmd     = 8'd0;
        req_ch.min_limit     = 8'd0;
        req_ch.min_limit_on  = 1'b0;
        req_ch.max_limit     = 8'd0;
        req_ch.max_limit_on  = 1'b0;
        req_ch.release_ticks = 16'd0;
        req_ch.release_on    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            offer_request(dir_table[i].req, dir_table[i].typed,
                          dir_table[i].has_write, dir_table[i].write);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle_send = ((n / 100) % 4 == 3);
            if (n == 300)
                long_hold_req = 1'b1;
            if (n == 600)
            begin
                // Let the block run dry before going on.
                req_ch.valid <= 1'b0;
                while (writes_due.size() != 0)
                    @(posedge clk);
            end
            // Runs of ticks drain the pending flags so that idle ticks occur too.
            if (burst_left == 0 && $urandom_range(0, 49) == 0)
                burst_left = 25;
            r = draw_request(burst_left > 0);
            if (burst_left > 0)
                burst_left--;
            offer_request(r, 1'b0, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (writes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, %0d of them ticks (%0d found nothing pending).",
                 sent_count, tick_count, idle_ticks);
        $display("Checked %0d servo writes, %0d mismatches.", writes_seen, errors);
        if (errors == 0 && writes_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
